>>> src/lliob_pkg.sv
// shared constants, codes and the busy-count table of the lcd/led/interrupt block
package lliob_pkg;

  localparam int unsigned QueueDepthDefault = 13;
  localparam int unsigned QCNT_W = 4;
  localparam int unsigned BUSY_W = 5;
  localparam int unsigned LED_W  = 9;

  // bus request codes
  localparam logic [1:0] FUNC_READ  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // result item kinds
  localparam logic [1:0] KIND_STATUS = 2'd0;
  localparam logic [1:0] KIND_CMD    = 2'd1;
  localparam logic [1:0] KIND_DATA   = 2'd2;

  // register offsets
  localparam logic [7:0] OFF_LED_DATA = 8'h00;
  localparam logic [7:0] OFF_LED_COM  = 8'h01;
  localparam logic [7:0] OFF_IRQ_ACK  = 8'h04;
  localparam logic [7:0] OFF_IRQ_MASK = 8'h05;
  localparam logic [7:0] OFF_FLUSH    = 8'h1E;
  localparam logic [7:0] OFF_CMD      = 8'h1F;
  localparam logic [7:0] OFF_Q_FIRST  = 8'h20;
  localparam logic [7:0] OFF_Q_LAST   = 8'h2C;

  // frames busy after a flush: ceil(40 * (sent + 1) * 32 / 1000)
  function automatic logic [BUSY_W-1:0] busy_frames(input logic [QCNT_W-1:0] sent);
    logic [BUSY_W-1:0] r;
    begin
      case (sent)
        4'd0:    r = 5'd2;
        4'd1:    r = 5'd3;
        4'd2:    r = 5'd4;
        4'd3:    r = 5'd6;
        4'd4:    r = 5'd7;
        4'd5:    r = 5'd8;
        4'd6:    r = 5'd9;
        4'd7:    r = 5'd11;
        4'd8:    r = 5'd12;
        4'd9:    r = 5'd13;
        4'd10:   r = 5'd15;
        4'd11:   r = 5'd16;
        4'd12:   r = 5'd17;
        4'd13:   r = 5'd18;
        4'd14:   r = 5'd20;
        default: r = 5'd21;
      endcase
      return r;
    end
  endfunction

endpackage

>>> src/lcd_led_interrupt_io_block_top.sv
// top level of the lcd/led/interrupt i/o block: register file, lcd queue and flush sequencer
//
// usage
//   input channel (in_valid / in_stall) carries one bus request: func selects a register
//   read, a register write or a frame tick; reg_offset and write_byte go with it
//   output channel (out_valid / out_stall) returns result items: for a flush write the
//   armed lcd command (kind 1) and the queued lcd bytes (kind 2), then always one status
//   item (kind 0) with last set; every item carries irq_line and led_lines after the request
// sequencing
//   one request at a time; in_stall is low only while the sequencer is idle
//   read, write or tick: the status item is loaded from S_READ or S_STATUS once the result
//   register is free; the block takes no new request before then
//   flush write: the armed command, if any, is loaded first, then each queued byte needs
//   a queue memory read in S_FLUSH and a move of its data out in S_QWAIT; S_STATUS ends it
// reset
//   synchronous rst clears control state; the 256 byte register file is cleared through
//   one valid bit per entry, so no clearing pass is needed and requests are taken at once
// stall
//   the result register holds while out_stall is high and the sequencer waits in place;
//   a request already taken keeps its status until the register frees up
module lcd_led_interrupt_io_block_top
  import lliob_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       func,
  input  logic [7:0]       reg_offset,
  input  logic [7:0]       write_byte,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       kind,
  output logic [7:0]       value,
  output logic             irq_line,
  output logic [LED_W-1:0] led_lines,
  output logic             last
);

  // queue memory address width, at least one bit
  localparam int unsigned QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_STATUS,
    S_FLUSH,
    S_QWAIT
  } state_t;

  state_t state;

  // register file memory, one valid bit per entry stands in for the zero reset
  logic [7:0]   rf_mem [256];
  logic [7:0]   rf_rdata;
  logic [255:0] rf_valid;
  logic         rf_rvalid;

  // lcd byte queue memory, contents undefined until written
  logic [7:0] q_mem [QUEUE_DEPTH];
  logic [7:0] q_rdata;

  // block state
  logic [7:0]        pending_sources;
  logic [7:0]        source_mask;
  logic [LED_W-1:0]  led_state;
  logic [7:0]        led_data;
  logic [7:0]        led_com;
  logic [7:0]        cmd_byte;
  logic              command_armed;
  logic [QCNT_W-1:0] queue_count;
  logic [BUSY_W-1:0] busy_frames_left;

  // sequencer working registers
  logic [7:0]        stat_value;
  logic              cmd_pend;
  logic [QCNT_W-1:0] fl_idx;
  logic [QCNT_W-1:0] fl_cnt;

  logic              accept;
  logic              out_free;
  logic              rf_we;
  logic              rf_re;
  logic              q_in_range;
  logic              q_we;
  logic              q_re;
  logic [7:0]        active;
  logic [7:0]        ack_value;
  logic [7:0]        ack_clear;
  logic              irq_next;
  logic [7:0]        pending_next;
  logic [QCNT_W-1:0] sent;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  assign rf_we      = accept && (func == FUNC_WRITE);
  assign rf_re      = accept && (func == FUNC_READ);
  assign q_in_range = (reg_offset >= OFF_Q_FIRST) && (reg_offset <= OFF_Q_LAST);
  assign q_we       = rf_we && q_in_range && (queue_count < QCNT_W'(QUEUE_DEPTH));
  assign q_re       = (state == S_FLUSH) && !cmd_pend && (fl_idx < fl_cnt);

  // lowest active source for an acknowledge read
  always_comb begin
    active    = pending_sources & ~source_mask;
    ack_value = 8'd0;
    ack_clear = 8'd0;
    for (int s = 7; s >= 0; s--) begin
      if (active[s]) begin
        ack_value = 8'(s + 1);
        ack_clear = 8'(1) << s;
      end
    end
  end

  assign sent = queue_count + QCNT_W'(command_armed);

  // irq level seen by the item loaded this cycle (state is already settled by then)
  assign pending_next = pending_sources;
  assign irq_next     = |(pending_next & ~source_mask);

  // register file: written on a write request, read on a read request
  always_ff @(posedge clk) begin
    if (rf_we) begin
      rf_mem[reg_offset] <= write_byte;
    end
    if (rf_re) begin
      rf_rdata <= rf_mem[reg_offset];
    end
  end

  // lcd queue: written while idle, read only during a flush, so no overlap
  always_ff @(posedge clk) begin
    if (q_we) begin
      q_mem[queue_count[QIDX_W-1:0]] <= write_byte;
    end
    if (q_re) begin
      q_rdata <= q_mem[fl_idx[QIDX_W-1:0]];
    end
  end

  // sequencer, block state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      rf_valid         <= '0;
      rf_rvalid        <= 1'b0;
      pending_sources  <= '0;
      source_mask      <= '0;
      led_state        <= '0;
      led_data         <= '0;
      led_com          <= '0;
      cmd_byte         <= '0;
      command_armed    <= 1'b0;
      queue_count      <= '0;
      busy_frames_left <= '0;
      stat_value       <= '0;
      cmd_pend         <= 1'b0;
      fl_idx           <= '0;
      fl_cnt           <= '0;
      out_valid        <= 1'b0;
      kind             <= KIND_STATUS;
      value            <= '0;
      irq_line         <= 1'b0;
      led_lines        <= '0;
      last             <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            stat_value <= 8'd0;
            state      <= S_STATUS;
            unique case (func)
              FUNC_READ: begin
                if (reg_offset == OFF_IRQ_ACK) begin
                  // acknowledge the lowest active source
                  stat_value      <= ack_value;
                  pending_sources <= pending_sources & ~ack_clear;
                end else begin
                  rf_rvalid <= rf_valid[reg_offset];
                  state     <= S_READ;
                end
              end
              FUNC_WRITE: begin
                rf_valid[reg_offset] <= 1'b1;
                if (reg_offset == OFF_LED_DATA) begin
                  led_data  <= write_byte;
                  led_state <= {led_com[1], led_com[0] ? 8'd0 : write_byte};
                end else if (reg_offset == OFF_LED_COM) begin
                  led_com   <= write_byte;
                  led_state <= {write_byte[1], write_byte[0] ? 8'd0 : led_data};
                end else if (reg_offset == OFF_IRQ_MASK) begin
                  source_mask <= write_byte;
                end else if (reg_offset == OFF_FLUSH) begin
                  // command first, then the queued bytes
                  cmd_pend         <= command_armed;
                  fl_idx           <= '0;
                  fl_cnt           <= queue_count;
                  command_armed    <= 1'b0;
                  queue_count      <= '0;
                  busy_frames_left <= busy_frames(sent);
                  state            <= S_FLUSH;
                end else if (reg_offset == OFF_CMD) begin
                  cmd_byte      <= write_byte;
                  command_armed <= 1'b1;
                end else if (q_we) begin
                  queue_count <= queue_count + QCNT_W'(1);
                end
              end
              FUNC_TICK: begin
                if (busy_frames_left != '0) begin
                  busy_frames_left <= busy_frames_left - BUSY_W'(1);
                  if (busy_frames_left == BUSY_W'(1)) begin
                    pending_sources <= pending_sources | 8'd1;
                  end
                end
              end
              default: begin
                // unknown request: status only
              end
            endcase
          end
        end

        S_READ: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind      <= KIND_STATUS;
            value     <= rf_rvalid ? rf_rdata : 8'd0;
            irq_line  <= irq_next;
            led_lines <= led_state;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_STATUS: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind      <= KIND_STATUS;
            value     <= stat_value;
            irq_line  <= irq_next;
            led_lines <= led_state;
            last      <= 1'b1;
            state     <= S_IDLE;
          end
        end

        S_FLUSH: begin
          if (cmd_pend) begin
            if (out_free) begin
              out_valid <= 1'b1;
              kind      <= KIND_CMD;
              value     <= cmd_byte;
              irq_line  <= irq_next;
              led_lines <= led_state;
              last      <= 1'b0;
              cmd_pend  <= 1'b0;
            end
          end else if (fl_idx < fl_cnt) begin
            // queue read issued this cycle
            state <= S_QWAIT;
          end else begin
            state <= S_STATUS;
          end
        end

        S_QWAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            kind      <= KIND_DATA;
            value     <= q_rdata;
            irq_line  <= irq_next;
            led_lines <= led_state;
            last      <= 1'b0;
            fl_idx    <= fl_idx + QCNT_W'(1);
            state     <= S_FLUSH;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // the queue never holds more bytes than it has entries
  assert property (@(posedge clk) disable iff (rst)
    queue_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("lcd queue count beyond depth");

  // a queue byte is moved out only for an entry that the flush still owes
  assert property (@(posedge clk) disable iff (rst)
    (state == S_QWAIT) |-> (fl_idx < fl_cnt))
    else $error("flush reads past the queued bytes");

  // the last busy frame raises source zero
  assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_TICK) && (busy_frames_left == BUSY_W'(1)))
      |=> (pending_sources[0] && (busy_frames_left == '0)))
    else $error("end of busy count did not raise source zero");

  // a flush leaves the command disarmed and the queue empty
  assert property (@(posedge clk) disable iff (rst)
    (rf_we && (reg_offset == OFF_FLUSH)) |=> (!command_armed && (queue_count == '0)))
    else $error("flush did not empty the lcd queue");

endmodule

>>> tb/tb_lcd_led_interrupt_io_block_top.sv
// self-checking testbench for the lcd/led/interrupt i/o block with a scoreboard class
module tb_lcd_led_interrupt_io_block_top;
  import lliob_pkg::*;

  // the one func code that the package leaves unnamed: the block must answer it with a bare status
  localparam logic [1:0] FUNC_SPARE = 2'd3;

  // flush timing: busy frames = ceil(40 * (bytes + 1) * 32 / 1000)
  localparam int unsigned FRAME_COST  = 40;
  localparam int unsigned FRAME_SCALE = 32;
  localparam int unsigned ROUND_UP    = 999;
  localparam int unsigned PER_MILLE   = 1000;

  localparam int unsigned RANDOM_REQUESTS = 460;
  localparam int unsigned DRAIN_CYCLES    = 40;

  // one result item as it leaves the block
  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       value;
    logic             irq_line;
    logic [LED_W-1:0] led_lines;
    logic             last;
  } io_item_t;

  // mirror of the block state, the expected result items and the mismatch count
  class lcd_io_scoreboard;
    logic [7:0]       regs [256];
    logic [7:0]       pending_src;
    logic [7:0]       src_mask;
    logic [LED_W-1:0] led_now;
    logic [7:0]       lcd_bytes [QueueDepthDefault];
    int unsigned      queued;
    bit               cmd_armed;
    int unsigned      busy_left;
    io_item_t         expected_items [$];
    int unsigned      mismatches;
    int unsigned      items_checked;
    int unsigned      flushes;
    int unsigned      lcd_items_sent;
    int unsigned      irq_acks;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (lcd_bytes[i]) lcd_bytes[i] = '0;
      pending_src = '0;
      src_mask    = '0;
      led_now     = '0;
      queued      = 0;
      cmd_armed   = 0;
      busy_left   = 0;
    endfunction

    // work out the items that one accepted request must cause
    function void note_request(logic [1:0] f, logic [7:0] off, logic [7:0] b);
      io_item_t    lcd_items [$];
      io_item_t    item;
      logic [7:0]  status;
      logic [7:0]  active;
      int unsigned sent;
      bit          found;
      status = '0;
      item   = '0;
      found  = 0;
      case (f)
        FUNC_READ: begin
          if (off == OFF_IRQ_ACK) begin
            active = pending_src & ~src_mask;
            for (int s = 0; s < 8; s++) begin
              if (!found && active[s]) begin
                pending_src[s] = 1'b0;
                status = 8'(s + 1);
                found = 1;
                irq_acks++;
              end
            end
          end else begin
            status = regs[off];
          end
        end
        FUNC_WRITE: begin
          regs[off] = b;
          if (off == OFF_LED_DATA || off == OFF_LED_COM) begin
            led_now = {regs[OFF_LED_COM][1], regs[OFF_LED_COM][0] ? 8'h00 : regs[OFF_LED_DATA]};
          end else if (off == OFF_IRQ_MASK) begin
            src_mask = b;
          end else if (off == OFF_FLUSH) begin
            sent = queued;
            if (cmd_armed) begin
              item.kind  = KIND_CMD;
              item.value = regs[OFF_CMD];
              lcd_items.push_back(item);
              sent++;
            end
            for (int i = 0; i < int'(queued); i++) begin
              item.kind  = KIND_DATA;
              item.value = lcd_bytes[i];
              lcd_items.push_back(item);
            end
            cmd_armed = 0;
            queued    = 0;
            busy_left = (FRAME_COST * (sent + 1) * FRAME_SCALE + ROUND_UP) / PER_MILLE;
            flushes++;
            lcd_items_sent += lcd_items.size();
          end else if (off == OFF_CMD) begin
            cmd_armed = 1;
          end else if (off >= OFF_Q_FIRST && off <= OFF_Q_LAST && queued < QueueDepthDefault) begin
            lcd_bytes[queued] = b;
            queued++;
          end
        end
        FUNC_TICK: begin
          if (busy_left != 0) begin
            busy_left--;
            if (busy_left == 0) pending_src[0] = 1'b1;
          end
        end
        default: begin
        end
      endcase
      // every item carries irq and leds as they stand once the request is done
      foreach (lcd_items[i]) begin
        lcd_items[i].irq_line  = (pending_src & ~src_mask) != 0;
        lcd_items[i].led_lines = led_now;
        lcd_items[i].last      = 1'b0;
        expected_items.push_back(lcd_items[i]);
      end
      item.kind      = KIND_STATUS;
      item.value     = status;
      item.irq_line  = (pending_src & ~src_mask) != 0;
      item.led_lines = led_now;
      item.last      = 1'b1;
      expected_items.push_back(item);
    endfunction

    task report_mismatch(string what, int unsigned got, int unsigned want);
      $display("mismatch on %s: got 0x%0h, expected 0x%0h (item %0d)", what, got, want,
               items_checked);
      mismatches++;
    endtask

    task check_result(io_item_t got);
      io_item_t want;
      if (expected_items.size() == 0) begin
        report_mismatch("unexpected item", 32'(got), 0);
      end else begin
        want = expected_items.pop_front();
        if (got.kind !== want.kind)
          report_mismatch("kind", 32'(got.kind), 32'(want.kind));
        if (got.value !== want.value)
          report_mismatch("value", 32'(got.value), 32'(want.value));
        if (got.irq_line !== want.irq_line)
          report_mismatch("irq_line", 32'(got.irq_line), 32'(want.irq_line));
        if (got.led_lines !== want.led_lines)
          report_mismatch("led_lines", 32'(got.led_lines), 32'(want.led_lines));
        if (got.last !== want.last)
          report_mismatch("last", 32'(got.last), 32'(want.last));
      end
      items_checked++;
    endtask
  endclass

  // clock and reset
  logic clk = 1'b0;
  logic rst = 1'b1;

  // request side, driven by the stimulus process
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] req_func = '0;
  logic [7:0] req_offset = '0;
  logic [7:0] req_byte = '0;

  // result side, stall driven by the sink process
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       res_kind;
  logic [7:0]       res_value;
  logic             res_irq;
  logic [LED_W-1:0] res_leds;
  logic             res_last;

  // when set, neither side idles, giving back-to-back stretches
  bit calm = 0;

  int unsigned      n_requests = 0;
  lcd_io_scoreboard sb = new();

  always #5 clk = ~clk;

  lcd_led_interrupt_io_block_top i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .func       (req_func),
    .reg_offset (req_offset),
    .write_byte (req_byte),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .kind       (res_kind),
    .value      (res_value),
    .irq_line   (res_irq),
    .led_lines  (res_leds),
    .last       (res_last)
  );

  // idle cycles drawn afresh for every request and every result item
  function automatic int unsigned idle_draw();
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // present one request after a random gap and hold it until the block takes it;
  // called and returning at a rising edge, so valid gets one assignment per edge
  task automatic send_request(input logic [1:0] f, input logic [7:0] off, input logic [7:0] b);
    int unsigned gap;
    gap = idle_draw();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_func   <= f;
    req_offset <= off;
    req_byte   <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, off, b);
    n_requests++;
  endtask

  // any func, any offset, any byte
  task automatic send_noise();
    send_request(2'($urandom_range(0, 3)), 8'($urandom), 8'($urandom));
  endtask

  // result sink: stall for a random number of cycles, then take the next item
  initial begin
    int unsigned w;
    do @(posedge clk); while (rst);
    forever begin
      w = idle_draw();
      if (w != 0) begin
        out_stall <= 1'b1;
        repeat (w) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_result('{res_kind, res_value, res_irq, res_leds, res_last});
    end
  end

  // stimulus: directed opening, then random traffic, then drain and verdict
  initial begin
    int unsigned pick;
    int unsigned nbytes;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // acknowledge with nothing pending, a read of an untouched register, the spare func,
    // and a tick while the busy count is already zero
    send_request(FUNC_READ, OFF_IRQ_ACK, 8'h00);
    send_request(FUNC_READ, 8'hFF, 8'hFF);
    send_request(FUNC_SPARE, 8'hFF, 8'hFF);
    send_request(FUNC_TICK, 8'h00, 8'h00);

    // led lines: full data, data with the common line, blanked data, back to plain data
    send_request(FUNC_WRITE, OFF_LED_DATA, 8'hFF);
    send_request(FUNC_WRITE, OFF_LED_COM, 8'h02);
    send_request(FUNC_WRITE, OFF_LED_COM, 8'h03);
    send_request(FUNC_WRITE, OFF_LED_COM, 8'h00);

    // empty flush under a mask: source 0 goes pending after two frames but stays hidden,
    // then unmasking raises the line and the acknowledge clears it
    send_request(FUNC_WRITE, OFF_IRQ_MASK, 8'h01);
    send_request(FUNC_WRITE, OFF_FLUSH, 8'h00);
    send_request(FUNC_TICK, 8'h00, 8'h00);
    send_request(FUNC_TICK, 8'hFF, 8'hFF);
    send_request(FUNC_READ, OFF_IRQ_ACK, 8'h00);
    send_request(FUNC_WRITE, OFF_IRQ_MASK, 8'h00);
    send_request(FUNC_READ, OFF_IRQ_ACK, 8'h00);
    send_request(FUNC_READ, OFF_IRQ_ACK, 8'h00);

    // a byte written to the acknowledge register is stored but never read back there
    send_request(FUNC_WRITE, OFF_IRQ_ACK, 8'hAA);
    send_request(FUNC_READ, OFF_IRQ_ACK, 8'h00);

    // armed command plus the first and last queue offsets, then a flush
    send_request(FUNC_WRITE, OFF_CMD, 8'hFF);
    send_request(FUNC_WRITE, OFF_Q_FIRST, 8'h00);
    send_request(FUNC_WRITE, OFF_Q_LAST, 8'hFF);
    send_request(FUNC_WRITE, OFF_FLUSH, 8'hFF);
    send_request(FUNC_READ, OFF_CMD, 8'h00);

    // random part: lcd transfers for about half of the picks, with ticks to run out the busy count
    while (n_requests < RANDOM_REQUESTS) begin
      if ($urandom_range(0, 7) == 0) calm = !calm;
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        if ($urandom_range(0, 3) != 0) send_request(FUNC_WRITE, OFF_CMD, 8'($urandom));
        // now and then overfill the queue so that extra bytes are dropped
        nbytes = ($urandom_range(0, 4) == 0) ? $urandom_range(13, 16) : $urandom_range(0, 6);
        repeat (nbytes) begin
          if ($urandom_range(0, 9) == 0) send_noise();
          send_request(FUNC_WRITE, 8'(OFF_Q_FIRST + $urandom_range(0, 12)), 8'($urandom));
        end
        send_request(FUNC_WRITE, OFF_FLUSH, 8'($urandom));
        repeat ($urandom_range(0, 22)) send_request(FUNC_TICK, 8'($urandom), 8'($urandom));
        if ($urandom_range(0, 1) != 0) send_request(FUNC_READ, OFF_IRQ_ACK, 8'($urandom));
      end else if (pick < 7) begin
        case ($urandom_range(0, 2))
          0: send_request(FUNC_WRITE, OFF_LED_DATA, 8'($urandom));
          1: send_request(FUNC_WRITE, OFF_LED_COM, 8'($urandom));
          // mask source 0 only now and then, so the line gets to rise
          default: send_request(FUNC_WRITE, OFF_IRQ_MASK,
                                ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom) & 8'hFE);
        endcase
      end else if (pick < 9) begin
        send_request(FUNC_READ, ($urandom_range(0, 1) != 0) ? OFF_IRQ_ACK : 8'($urandom),
                     8'($urandom));
      end else begin
        send_noise();
      end
    end
    in_valid <= 1'b0;

    // drain, then keep watching in case something stray comes out
    while (sb.expected_items.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run: %0d requests, %0d result items checked", n_requests, sb.items_checked);
    $display("run: %0d lcd flushes sending %0d lcd items, %0d interrupt acknowledges",
             sb.flushes, sb.lcd_items_sent, sb.irq_acks);
    if (sb.mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
